@@ rtl/spf_pkg.sv @@
// Shared types and constants for the SPI response frame parser.
// No dependencies; imported by spf_parser and spi_response_frame_parser.
package spf_pkg;

	// Frame marker and shortest legal length byte
	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [7:0] MIN_LENGTH  = 8'd3;

	// Parse status codes, as seen on the parse_status port
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FRAME    = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_NONE     = 2'd3
	} spf_status_t;

	// Per-byte parse phase
	typedef enum logic [2:0] {
		PH_SEARCH  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_COMMAND = 3'd2,
		PH_FLAG    = 3'd3,
		PH_VALUE   = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_DONE    = 3'd6
	} spf_phase_t;

	// One transaction result handed from the parser to the output register
	typedef struct packed {
		spf_status_t status;
		logic [7:0]  command;
		logic [7:0]  flag;
		logic [7:0]  value;
	} spf_result_t;

endpackage

@@ rtl/spf_parser.sv @@
// Per-byte frame parser state machine: position count, header search,
// length check, XOR checksum and capture of command/flag/value. Uses spf_pkg.
module spf_parser #(
	parameter int TRANSACTION_BYTES = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output logic                last,
	output spf_pkg::spf_result_t result
);
	import spf_pkg::*;

	localparam int POS_W = $clog2(TRANSACTION_BYTES);
	localparam int SUM_W = ((POS_W > 8) ? POS_W : 8) + 1;
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(TRANSACTION_BYTES - 1);
	localparam logic [POS_W-1:0] HDR_LIMIT = POS_W'(TRANSACTION_BYTES - 3);
	localparam logic [SUM_W-1:0] TOTAL     = SUM_W'(TRANSACTION_BYTES);

	spf_phase_t        phase_q, phase_d;
	spf_status_t       status_q, status_d;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  csum_pos_q, csum_pos_d;
	logic [7:0]        xor_q, xor_d;
	logic [7:0]        cmd_q, cmd_d;
	logic [7:0]        flag_q, flag_d;
	logic [7:0]        val_q, val_d;
	logic [SUM_W-1:0]  csum_sum;
	logic              len_bad;
	logic              at_csum;

	// Checksum position implied by the length byte
	assign csum_sum = SUM_W'(pos_q) + SUM_W'(rx_byte) + SUM_W'(1);
	assign len_bad  = (rx_byte < MIN_LENGTH) || (csum_sum >= TOTAL);
	assign at_csum  = (pos_q == csum_pos_q);
	assign last     = (pos_q == LAST_POS);

	// Next phase and decision
	always_comb begin
		phase_d  = phase_q;
		status_d = status_q;
		unique case (phase_q)
			PH_SEARCH: begin
				if (rx_byte == HEADER_BYTE) begin
					if (pos_q >= HDR_LIMIT) begin
						phase_d  = PH_DONE;
						status_d = ST_FRAME;
					end else begin
						phase_d = PH_LENGTH;
					end
				end
			end
			PH_LENGTH: begin
				if (len_bad) begin
					phase_d  = PH_DONE;
					status_d = ST_FRAME;
				end else begin
					phase_d = PH_COMMAND;
				end
			end
			PH_COMMAND, PH_FLAG, PH_VALUE, PH_PAYLOAD: begin
				if (at_csum) begin
					phase_d  = PH_DONE;
					status_d = (xor_q == rx_byte) ? ST_OK : ST_CHECKSUM;
				end else if (phase_q == PH_COMMAND) begin
					phase_d = PH_FLAG;
				end else if (phase_q == PH_FLAG) begin
					phase_d = PH_VALUE;
				end else if (phase_q == PH_VALUE) begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
	end

	// Datapath updates: checksum position, running XOR, held bytes
	always_comb begin
		csum_pos_d = csum_pos_q;
		xor_d      = xor_q;
		cmd_d      = cmd_q;
		flag_d     = flag_q;
		val_d      = val_q;
		if (phase_q == PH_LENGTH) begin
			csum_pos_d = csum_sum[POS_W-1:0];
			xor_d      = rx_byte;
		end else if ((phase_q == PH_COMMAND || phase_q == PH_FLAG ||
				phase_q == PH_VALUE || phase_q == PH_PAYLOAD) && !at_csum) begin
			xor_d = xor_q ^ rx_byte;
			if (phase_q == PH_COMMAND) cmd_d = rx_byte;
			if (phase_q == PH_FLAG)    flag_d = rx_byte;
			if (phase_q == PH_VALUE)   val_d = rx_byte;
		end
	end

	// Result of the transaction, meaningful on its last byte
	always_comb begin
		result.status  = (phase_d == PH_DONE) ? status_d : ST_NONE;
		result.command = (result.status == ST_OK) ? cmd_d  : 8'd0;
		result.flag    = (result.status == ST_OK) ? flag_d : 8'd0;
		result.value   = (result.status == ST_OK) ? val_d  : 8'd0;
	end

	// State registers; the last byte starts a fresh transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEARCH;
			status_q   <= ST_NONE;
			pos_q      <= '0;
			csum_pos_q <= '0;
			xor_q      <= '0;
			cmd_q      <= '0;
			flag_q     <= '0;
			val_q      <= '0;
		end else if (step) begin
			if (last) begin
				phase_q    <= PH_SEARCH;
				status_q   <= ST_NONE;
				pos_q      <= '0;
				csum_pos_q <= '0;
				xor_q      <= '0;
				cmd_q      <= '0;
				flag_q     <= '0;
				val_q      <= '0;
			end else begin
				phase_q    <= phase_d;
				status_q   <= status_d;
				pos_q      <= pos_q + POS_W'(1);
				csum_pos_q <= csum_pos_d;
				xor_q      <= xor_d;
				cmd_q      <= cmd_d;
				flag_q     <= flag_d;
				val_q      <= val_d;
			end
		end
	end

endmodule

@@ rtl/spi_response_frame_parser.sv @@
// Top level of the SPI response frame parser: input register, parser, result register.
// Depends on spf_pkg and spf_parser.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_stall  | rx_byte
//   out      | out_valid / out_stall| parse_status, resp_command, resp_flag, resp_value
//
// One byte is taken per cycle unless in_stall is high; each byte waits in the
// input register and the parser state updates as it leaves. The last byte of
// a transaction loads the result register as it leaves. arst_n clears the
// parser to the start of a transaction and empties both registers. A stalled
// result only holds up the input when the byte waiting in the input register
// is the next transaction's last byte, which needs the result register.
module spi_response_frame_parser #(
	parameter int TRANSACTION_BYTES = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] parse_status,
	output logic [7:0] resp_command,
	output logic [7:0] resp_flag,
	output logic [7:0] resp_value
);
	import spf_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance_s1;
	logic        last;
	spf_result_t result;
	logic        out_valid_q;
	spf_result_t out_q;

	// The input stage moves on unless it holds a last byte and the result is blocked
	assign advance_s1 = valid_s1 && !(last && out_valid_q && out_stall);
	assign in_stall   = valid_s1 && !advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	spf_parser #(
		.TRANSACTION_BYTES(TRANSACTION_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance_s1),
		.rx_byte(byte_s1),
		.last   (last),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last) begin
			out_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign parse_status = out_q.status;
	assign resp_command = out_q.command;
	assign resp_flag    = out_q.flag;
	assign resp_value   = out_q.value;

endmodule
